[hw/rtl/sbtr_pkg.sv]
// shared types, constants and font table for the scaled bitmap text rasterizer
`default_nettype none

package sbtr_pkg;

    // font geometry
    localparam int FONT_GLYPHS   = 21;
    localparam int GLYPH_COLUMNS = 5;
    localparam int GLYPH_ROWS    = 7;
    localparam int GLYPH_CELLS   = GLYPH_COLUMNS * GLYPH_ROWS;
    localparam int ROW_BITS      = 8;
    localparam int ADVANCE_CELLS = 6;

    // field and datapath widths
    localparam int CODE_W   = 8;
    localparam int COORD_W  = 12;
    localparam int SIDE_W   = 4;
    localparam int ADDR_W   = 24;
    localparam int COLOR_W  = 32;
    localparam int STRIDE_W = 13;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int PEN_X_W  = 16;
    localparam int PEN_Y_W  = COORD_W;
    localparam int BX_W     = PEN_X_W + 1;
    localparam int BY_W     = PEN_Y_W + 1;
    localparam int FULL_ADDR_W = BY_W + STRIDE_W + 1;
    localparam int OFF_W    = 7;
    localparam int ADV_W    = 7;
    localparam int COL_W    = (GLYPH_COLUMNS > 1) ? $clog2(GLYPH_COLUMNS) : 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_COLOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE = 2'd2;

    // register reset values
    localparam logic [SIDE_W-1:0]   SCALE_RESET  = 4'd1;
    localparam logic [COLOR_W-1:0]  COLOR_RESET  = 32'hFFFF_FFFF;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd640;

    typedef struct packed {
        logic [CODE_W-1:0]  character;
        logic               begins_text;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
    } char_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] block_x;
        logic [COORD_W-1:0] block_y;
        logic [SIDE_W-1:0]  block_side;
        logic [ADDR_W-1:0]  pixel_address;
        logic [COLOR_W-1:0] color;
        logic               out_of_range;
        logic               last;
    } cmd_item_t;

    // one lit cell handed from the sequencer to the address unit
    typedef struct packed {
        logic [BX_W-1:0]   bx;
        logic [BY_W-1:0]   by;
        logic [SIDE_W-1:0] side;
        logic              last;
    } cell_t;

    localparam logic [CODE_W-1:0] GLYPH_CODE [FONT_GLYPHS] = '{
        8'h53, 8'h48, 8'h4F, 8'h54, 8'h49, 8'h4D, 8'h45, 8'h52, 8'h51, 8'h55,
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
        8'h20
    };

    // top row in the most significant byte, column 0 at bit 4 of each row
    localparam logic [GLYPH_ROWS*ROW_BITS-1:0] GLYPH_ROM [FONT_GLYPHS] = '{
        56'h0E10100E01011C, 56'h1111111F111111, 56'h0E11111111110E,
        56'h1F040404040404, 56'h0E04040404040E, 56'h111B1511111111,
        56'h1F10101E10101F, 56'h1E11111E141211, 56'h0E11111115120D,
        56'h1111111111110E, 56'h0E11131519110E, 56'h040C040404040E,
        56'h0E11010204081F, 56'h0E11010601110E, 56'h02060A121F0202,
        56'h1F101E0101110E, 56'h0608101E11110E, 56'h1F010204080808,
        56'h0E11110E11110E, 56'h0E11110F01020C, 56'h00000000000000
    };

    // lit cells of a code in walk order, cell 0 at bit 0; unknown codes are blank
    function automatic logic [GLYPH_CELLS-1:0] glyph_cells(input logic [CODE_W-1:0] code);
        logic [GLYPH_CELLS-1:0] cells;
        cells = '0;
        for (int g = 0; g < FONT_GLYPHS; g++) begin
            if (code == GLYPH_CODE[g]) begin
                for (int r = 0; r < GLYPH_ROWS; r++) begin
                    for (int c = 0; c < GLYPH_COLUMNS; c++) begin
                        cells[r*GLYPH_COLUMNS + c] =
                            GLYPH_ROM[g][(GLYPH_ROWS-1-r)*ROW_BITS + (GLYPH_COLUMNS-1-c)];
                    end
                end
            end
        end
        return cells;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/scaled_bitmap_text_rasterizer.sv]
// top level of the scaled bitmap text rasterizer: config registers and unit wiring
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  char    | in        | char_valid, char_stall | char_item (code, pen start)
//  cmd     | out       | cmd_valid, cmd_stall   | cmd_item (one lit block fill)
//  cfg     | in        | cfg_write              | cfg_index, cfg_data
//
//  the sequencer steps one glyph cell a cycle while advance is high; it accepts a
//  code, walks cells up to the last lit one and closes; a blank glyph only closes
//  each lit block passes a cell register and a stride multiply before the output
//  register; a cmd_stall while a command is held freezes the walk and both
//  stages, and the pen moves only at walk end
//  reset clears the pen to (0,0) and loads scale 1, white, stride 640
`default_nettype none

module scaled_bitmap_text_rasterizer
    import sbtr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 char_valid,
    output logic                      char_stall,
    input  wire char_item_t           char_item,
    output logic                      cmd_valid,
    input  wire logic                 cmd_stall,
    output cmd_item_t                 cmd_item,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    // configuration registers
    logic [SIDE_W-1:0]   scale_reg, scale_next;
    logic [COLOR_W-1:0]  fill_color_reg, fill_color_next;
    logic [STRIDE_W-1:0] row_stride_reg, row_stride_next;

    // walk to address unit
    logic   advance;
    logic   cell_valid;
    cell_t  walk_cell;

    // register write decode; an index past the list is ignored
    always_comb
    begin
        scale_next      = scale_reg;
        fill_color_next = fill_color_reg;
        row_stride_next = row_stride_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SCALE:      scale_next      = cfg_data[SIDE_W-1:0];
                CFG_FILL_COLOR: fill_color_next = cfg_data[COLOR_W-1:0];
                CFG_ROW_STRIDE: row_stride_next = cfg_data[STRIDE_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg      <= SCALE_RESET;
            fill_color_reg <= COLOR_RESET;
            row_stride_reg <= STRIDE_RESET;
        end
        else
        begin
            scale_reg      <= scale_next;
            fill_color_reg <= fill_color_next;
            row_stride_reg <= row_stride_next;
        end
    end

    // glyph cell walk, pen tracking
    sbtr_sequencer u_sequencer (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item),
        .scale      (scale_reg),
        .advance    (advance),
        .cell_valid (cell_valid),
        .walk_cell  (walk_cell)
    );

    // frame address, range flag and command output
    sbtr_addr_unit u_addr_unit (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_valid (cell_valid),
        .walk_cell  (walk_cell),
        .row_stride (row_stride_reg),
        .fill_color (fill_color_reg),
        .advance    (advance),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd_item   (cmd_item)
    );

endmodule

`default_nettype wire

[hw/rtl/sbtr_sequencer.sv]
// cell walk sequencer: pen state, glyph lookup and block offsets
`default_nettype none

module sbtr_sequencer
    import sbtr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               char_valid,
    output logic                    char_stall,
    input  wire char_item_t         char_item,
    input  wire logic [SIDE_W-1:0]  scale,
    input  wire logic               advance,
    output logic                    cell_valid,
    output cell_t                   walk_cell
);

    typedef enum logic [1:0] {
        SEQ_IDLE = 2'b01,
        SEQ_SCAN = 2'b10
    } seq_state_t;

    seq_state_t              state_reg, state_next;
    logic [PEN_X_W-1:0]      pen_x_reg, pen_x_next;
    logic [PEN_Y_W-1:0]      pen_y_reg, pen_y_next;
    logic [GLYPH_CELLS-1:0]  cells_reg, cells_next;
    logic [COL_W-1:0]        col_reg, col_next;
    logic [OFF_W-1:0]        col_off_reg, col_off_next;
    logic [OFF_W-1:0]        row_off_reg, row_off_next;
    logic [SIDE_W-1:0]       side_reg, side_next;

    logic                    accept;
    logic [ADV_W-1:0]        adv;
    logic [BX_W-1:0]         pen_sum;

    assign char_stall = (state_reg != SEQ_IDLE);
    assign accept     = char_valid && !char_stall;

    // advance of six cells: side*4 + side*2
    assign adv     = {1'b0, side_reg, 2'b00} + {2'b00, side_reg, 1'b0};
    assign pen_sum = {1'b0, pen_x_reg} + BX_W'(adv);

    assign walk_cell.bx   = {1'b0, pen_x_reg} + BX_W'(col_off_reg);
    assign walk_cell.by   = {1'b0, pen_y_reg} + BY_W'(row_off_reg);
    assign walk_cell.side = side_reg;
    assign walk_cell.last = (cells_reg[GLYPH_CELLS-1:1] == '0);
    assign cell_valid = (state_reg == SEQ_SCAN) && advance && cells_reg[0];

    always_comb
    begin
        state_next   = state_reg;
        pen_x_next   = pen_x_reg;
        pen_y_next   = pen_y_reg;
        cells_next   = cells_reg;
        col_next     = col_reg;
        col_off_next = col_off_reg;
        row_off_next = row_off_reg;
        side_next    = side_reg;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (accept)
                begin
                    if (char_item.begins_text)
                    begin
                        pen_x_next = PEN_X_W'(char_item.start_x);
                        pen_y_next = char_item.start_y;
                    end
                    cells_next   = glyph_cells(char_item.character);
                    col_next     = '0;
                    col_off_next = '0;
                    row_off_next = '0;
                    side_next    = (scale == '0) ? SIDE_W'(1) : scale;
                    state_next   = SEQ_SCAN;
                end
            end
            SEQ_SCAN:
            begin
                if (cells_reg == '0)
                begin
                    // no lit cells left: move the pen, saturating
                    pen_x_next = pen_sum[BX_W-1] ? '1 : pen_sum[PEN_X_W-1:0];
                    state_next = SEQ_IDLE;
                end
                else if (advance)
                begin
                    cells_next = cells_reg >> 1;
                    if (col_reg == COL_W'(GLYPH_COLUMNS - 1))
                    begin
                        col_next     = '0;
                        col_off_next = '0;
                        row_off_next = row_off_reg + OFF_W'(side_reg);
                    end
                    else
                    begin
                        col_next     = col_reg + COL_W'(1);
                        col_off_next = col_off_reg + OFF_W'(side_reg);
                    end
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            pen_x_reg <= '0;
            pen_y_reg <= '0;
            cells_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pen_x_reg <= pen_x_next;
            pen_y_reg <= pen_y_next;
            cells_reg <= cells_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg     <= col_next;
        col_off_reg <= col_off_next;
        row_off_reg <= row_off_next;
        side_reg    <= side_next;
    end

endmodule

`default_nettype wire

[hw/rtl/sbtr_addr_unit.sv]
// address unit: cell register, stride multiply, range check and output register
`default_nettype none

module sbtr_addr_unit
    import sbtr_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cell_valid,
    input  wire cell_t               walk_cell,
    input  wire logic [STRIDE_W-1:0] row_stride,
    input  wire logic [COLOR_W-1:0]  fill_color,
    output logic                     advance,
    output logic                     cmd_valid,
    input  wire logic                cmd_stall,
    output cmd_item_t                cmd_item
);

    logic                    a_valid_reg;
    cell_t                   a_reg;
    logic                    out_valid_reg;
    cmd_item_t               out_reg, out_next;
    logic [FULL_ADDR_W-1:0]  full_addr;

    assign advance   = !out_valid_reg || !cmd_stall;
    assign cmd_valid = out_valid_reg;
    assign cmd_item  = out_reg;

    assign full_addr = FULL_ADDR_W'(a_reg.by * row_stride) + FULL_ADDR_W'(a_reg.bx);

    always_comb
    begin
        out_next.block_x       = a_reg.bx[COORD_W-1:0];
        out_next.block_y       = a_reg.by[COORD_W-1:0];
        out_next.block_side    = a_reg.side;
        out_next.pixel_address = full_addr[ADDR_W-1:0];
        out_next.color         = fill_color;
        out_next.out_of_range  = (a_reg.bx[BX_W-1:COORD_W] != '0)
                              || (a_reg.by[BY_W-1:COORD_W] != '0)
                              || (full_addr[FULL_ADDR_W-1:ADDR_W] != '0);
        out_next.last          = a_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg   <= cell_valid;
            out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_reg   <= walk_cell;
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

[dv/scaled_bitmap_text_rasterizer_test.sv]
// self-checking testbench for the scaled bitmap text rasterizer: predicts block fill commands
module scaled_bitmap_text_rasterizer_test;
    import sbtr_pkg::*;

    // run limits and reporting
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF       = 50;
    localparam int REPORT_MAX     = 10;
    localparam int TEXT_ITEMS     = 40;
    localparam int OVERRUN_ITEMS  = 40;

    // geometry of the font as the predictor sees it
    localparam int FONT_SIZE  = 21;
    localparam int BLANK_SLOT = 20;
    localparam int CELL_COLS  = 5;
    localparam int CELL_ROWS  = 7;
    localparam int MAX_CMDS   = 19;
    localparam int unsigned PEN_STEP    = 6;
    localparam int unsigned PEN_X_LIMIT = 65535;
    localparam int unsigned COORD_LIMIT = 4095;
    localparam int unsigned ADDR_LIMIT  = 16777215;
    localparam logic [CODE_W-1:0] SPACE_CODE = 8'h20;

    // codes of the font: S H O T I M E R Q U, digits 0 to 9, then space
    localparam logic [7:0] FONT_CODE [FONT_SIZE] = '{
        8'h53, 8'h48, 8'h4F, 8'h54, 8'h49, 8'h4D, 8'h45, 8'h52, 8'h51, 8'h55,
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
        8'h20
    };

    // one byte per row, top row in the top byte, leftmost cell at bit 4 of the byte
    localparam logic [55:0] FONT_ROWS [FONT_SIZE] = '{
        56'h0E10100E01011C, 56'h1111111F111111, 56'h0E11111111110E,
        56'h1F040404040404, 56'h0E04040404040E, 56'h111B1511111111,
        56'h1F10101E10101F, 56'h1E11111E141211, 56'h0E11111115120D,
        56'h1111111111110E, 56'h0E11131519110E, 56'h040C040404040E,
        56'h0E11010204081F, 56'h0E11010601110E, 56'h02060A121F0202,
        56'h1F101E0101110E, 56'h0608101E11110E, 56'h1F010204080808,
        56'h0E11110E11110E, 56'h0E11110F01020C, 56'h00000000000000
    };

    // registers in the order they are written
    localparam logic [CFG_IDX_W-1:0] REG_ORDER [3] = '{CFG_SCALE, CFG_FILL_COLOR, CFG_ROW_STRIDE};

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

    // register copy, pen and the queue of block commands still owed
    class raster_scoreboard;
        bit [SIDE_W-1:0]   scale      = SCALE_RESET;
        bit [COLOR_W-1:0]  fill_color = COLOR_RESET;
        bit [STRIDE_W-1:0] row_stride = STRIDE_RESET;
        bit [15:0]         pen_x      = '0;
        bit [11:0]         pen_y      = '0;
        cmd_item_t         owed_cmds[$];
        int chars_seen, lit_chars, cmds_checked, oor_cmds, mismatches;
        bit pen_saturated;

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
            case (index)
                CFG_SCALE:      scale = data[SIDE_W-1:0];
                CFG_FILL_COLOR: fill_color = data;
                CFG_ROW_STRIDE: row_stride = data[STRIDE_W-1:0];
                default: ;
            endcase
        endfunction

        function int glyph_slot(logic [CODE_W-1:0] code);
            for (int g = 0; g < FONT_SIZE; g++)
                if (FONT_CODE[g] == code)
                    return g;
            return BLANK_SLOT;
        endfunction

        // works out the fill commands of one accepted character and moves the pen
        function void plot_char(char_item_t item);
            int unsigned side, bx, by, addr, next_x;
            int slot, made;
            logic [7:0] row_bits;
            cmd_item_t cmd, held;
            bit have_held;
            side = (scale == 0) ? 1 : scale;
            if (item.begins_text)
            begin
                pen_x = 16'(item.start_x);
                pen_y = item.start_y;
            end
            slot = glyph_slot(item.character);
            made = 0;
            have_held = 0;
            for (int row = 0; row < CELL_ROWS; row++)
            begin
                row_bits = FONT_ROWS[slot][(CELL_ROWS-1-row)*8 +: 8];
                for (int col = 0; col < CELL_COLS; col++)
                begin
                    if (row_bits[CELL_COLS-1-col] && made < MAX_CMDS)
                    begin
                        bx = pen_x + col * side;
                        by = pen_y + row * side;
                        addr = by * row_stride + bx;
                        cmd.block_x       = bx[COORD_W-1:0];
                        cmd.block_y       = by[COORD_W-1:0];
                        cmd.block_side    = side[SIDE_W-1:0];
                        cmd.pixel_address = addr[ADDR_W-1:0];
                        cmd.color         = fill_color;
                        cmd.out_of_range  = (bx > COORD_LIMIT) || (by > COORD_LIMIT)
                                            || (addr > ADDR_LIMIT);
                        cmd.last          = 1'b0;
                        if (have_held)
                            owed_cmds.push_back(held);
                        held = cmd;
                        have_held = 1;
                        made++;
                    end
                end
            end
            if (have_held)
            begin
                held.last = 1'b1;
                owed_cmds.push_back(held);
                lit_chars++;
            end
            chars_seen++;
            next_x = pen_x + PEN_STEP * side;
            if (next_x > PEN_X_LIMIT)
            begin
                pen_x = PEN_X_LIMIT;
                pen_saturated = 1;
            end
            else
                pen_x = next_x[15:0];
        endfunction

        function void check_cmd(cmd_item_t got);
            cmd_item_t want;
            if (owed_cmds.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: command with none owed: x=%h y=%h addr=%h last=%b",
                             $time, got.block_x, got.block_y, got.pixel_address, got.last);
                return;
            end
            want = owed_cmds.pop_front();
            cmds_checked++;
            if (want.out_of_range)
                oor_cmds++;
            if (got.block_x !== want.block_x || got.block_y !== want.block_y
                || got.block_side !== want.block_side
                || got.pixel_address !== want.pixel_address || got.color !== want.color
                || got.out_of_range !== want.out_of_range || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $display("%0t: command mismatch, expected x=%h y=%h side=%h addr=%h",
                             $time, want.block_x, want.block_y, want.block_side,
                             want.pixel_address);
                    $display("    color=%h oor=%b last=%b",
                             want.color, want.out_of_range, want.last);
                    $display("%0t:                     actual x=%h y=%h side=%h addr=%h",
                             $time, got.block_x, got.block_y, got.block_side,
                             got.pixel_address);
                    $display("    color=%h oor=%b last=%b",
                             got.color, got.out_of_range, got.last);
                end
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n      = 1'b0;
    logic                 char_valid = 1'b0;
    logic                 char_stall;
    char_item_t           char_item  = '0;
    logic                 cmd_valid;
    logic                 cmd_stall  = 1'b0;
    cmd_item_t            cmd_item;
    logic                 cfg_write  = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [CFG_W-1:0]     cfg_data   = '0;

    raster_scoreboard sb = new();

    // stimulus shaping
    stall_mode_t stall_mode  = STALL_NONE;
    bit          stall_hold  = 1'b0;
    bit          sender_idles;
    int          burst_left  = 0;
    int          stall_run   = 0;
    int          idle_cycles = 0;

    scaled_bitmap_text_rasterizer i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd_item   (cmd_item),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver back-pressure: runs of stall or flow whose length and duty depend on the mode,
    // forced off while registers are being rewritten so the block can settle
    always @(posedge clk)
    begin
        if (stall_hold || stall_mode == STALL_NONE)
        begin
            cmd_stall <= 1'b0;
            stall_run <= 0;
        end
        else if (stall_run != 0)
            stall_run <= stall_run - 1;
        else
        begin
            stall_run <= (stall_mode == STALL_HEAVY) ? $urandom_range(0, 15)
                                                     : $urandom_range(0, 3);
            cmd_stall <= ($urandom_range(0, 99) < ((stall_mode == STALL_HEAVY) ? 60 : 25));
        end
    end

    // both channels are sampled on the pre-edge values, so acceptance here matches the block
    always @(posedge clk)
    begin
        if (char_valid && !char_stall)
            sb.plot_char(char_item);
        if (cmd_valid && !cmd_stall)
            sb.check_cmd(cmd_item);
        if ((char_valid && !char_stall) || (cmd_valid && !cmd_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog, nothing accepted for %0d cycles, %0d commands owed",
                     $time, idle_cycles, sb.owed_cmds.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic char_item_t make_item(bit begins, logic [CODE_W-1:0] code,
                                             logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        char_item_t item;
        item.character   = code;
        item.begins_text = begins;
        item.start_x     = x;
        item.start_y     = y;
        return item;
    endfunction

    // presents one item and returns at the edge it is taken; bursts of items are
    // separated by random gaps when the sender is set to idle
    task automatic send_char(char_item_t item);
        int gap;
        gap = 0;
        if (sender_idles)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 12);
                burst_left = $urandom_range(1, 16);
            end
            else
                burst_left--;
        end
        if (gap != 0)
        begin
            char_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_item  <= item;
        char_valid <= 1'b1;
        do
            @(posedge clk);
        while (char_stall !== 1'b0);
    endtask

    // sender holds off until every owed command has come out
    task automatic drain_results();
        char_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.owed_cmds.size() != 0);
    endtask

    // rewrites all three registers once the block is idle; upper scale and stride data bits are junk
    task automatic configure(logic [SIDE_W-1:0] scale_val, logic [COLOR_W-1:0] color_val,
                             logic [STRIDE_W-1:0] stride_val);
        logic [CFG_W-1:0] data [3];
        logic [CFG_W-1:0] junk;
        drain_results();
        stall_hold <= 1'b1;
        // a blank glyph or the closing cycle may still be in flight with nothing owed
        repeat (HOLD_OFF) @(posedge clk);
        junk = $urandom;
        data[0] = {junk[CFG_W-1:SIDE_W], scale_val};
        data[1] = color_val;
        data[2] = {junk[CFG_W-1:STRIDE_W], stride_val};
        for (int i = 0; i < 3; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= REG_ORDER[i];
            cfg_data  <= data[i];
            @(posedge clk);
            sb.write_reg(REG_ORDER[i], data[i]);
        end
        cfg_write  <= 1'b0;
        stall_hold <= 1'b0;
    endtask

    // random texts: a restart with a fresh pen, then a run of continued characters,
    // mostly from the font; a few stray restarts and unknown codes mixed in
    task automatic run_texts(int count, bit with_pause);
        int text_left;
        char_item_t item;
        text_left = 0;
        for (int i = 0; i < count; i++)
        begin
            if (with_pause && i == count / 2)
                drain_results();
            item.start_x = COORD_W'($urandom_range(0, 4095));
            item.start_y = COORD_W'($urandom_range(0, 4095));
            if (text_left == 0)
            begin
                item.begins_text = 1'b1;
                text_left = $urandom_range(1, 10);
                // near the far corner so blocks run off the edges
                if ($urandom_range(0, 3) == 0)
                begin
                    item.start_x = COORD_W'($urandom_range(3800, 4095));
                    item.start_y = COORD_W'($urandom_range(3800, 4095));
                end
            end
            else
            begin
                item.begins_text = ($urandom_range(0, 19) == 0);
                text_left--;
            end
            if ($urandom_range(0, 4) == 0)
                item.character = CODE_W'($urandom_range(0, 255));
            else
                item.character = FONT_CODE[$urandom_range(0, FONT_SIZE - 1)];
            send_char(item);
        end
    endtask

    // one long text at the widest scale from the right edge, mostly blanks so the pen
    // runs far past the frame, with lit glyphs sprinkled in
    task automatic run_pen_overrun();
        char_item_t item;
        send_char(make_item(1'b1, SPACE_CODE, 12'hFFF, COORD_W'($urandom_range(0, 4095))));
        for (int i = 0; i < OVERRUN_ITEMS; i++)
        begin
            item.begins_text = 1'b0;
            item.start_x = COORD_W'($urandom_range(0, 4095));
            item.start_y = COORD_W'($urandom_range(0, 4095));
            if ($urandom_range(0, 9) == 0)
                item.character = FONT_CODE[$urandom_range(0, FONT_SIZE - 2)];
            else if ($urandom_range(0, 1) == 0)
                item.character = SPACE_CODE;
            else
                item.character = CODE_W'($urandom_range(128, 255));
            send_char(item);
        end
    endtask

    initial
    begin
        string tail;
        int failures;
        tail = "OTIRQU12345679";
        sender_idles = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items under reset settings
        stall_mode   <= STALL_LIGHT;
        sender_idles = 1'b1;
        // continuing before any text starts from the reset pen
        send_char(make_item(1'b0, 8'h48, COORD_W'($urandom_range(0, 4095)),
                            COORD_W'($urandom_range(0, 4095))));
        send_char(make_item(1'b0, 8'h53, 12'hFFF, 12'hFFF));
        send_char(make_item(1'b1, 8'h38, 12'h000, 12'h000));
        // unknown code draws nothing but still loads and moves the pen
        send_char(make_item(1'b1, 8'hFF, 12'hFFF, 12'hFFF));
        // lands beyond the right edge and the bottom: every block out of range
        send_char(make_item(1'b0, 8'h4D, 12'h000, 12'h000));
        send_char(make_item(1'b1, SPACE_CODE, 12'd100, 12'hFFF));
        // rows run past the bottom edge
        send_char(make_item(1'b0, 8'h45, 12'hFFF, 12'h000));
        send_char(make_item(1'b1, 8'h00, 12'hAAA, 12'h555));
        send_char(make_item(1'b1, 8'h30, 12'h555, 12'hAAA));
        for (int i = 0; i < tail.len(); i++)
            send_char(make_item(1'b0, tail[i], COORD_W'($urandom_range(0, 4095)),
                                COORD_W'($urandom_range(0, 4095))));

        // random phases over register settings, extremes first
        configure(4'd15, 32'h0000_0000, 13'd4096);
        stall_mode <= STALL_LIGHT;
        sender_idles = 1'b1;
        run_texts(TEXT_ITEMS, 1'b0);

        // zero scale behaves as one; stride of one; no idling on either side
        configure(4'd0, $urandom, 13'd1);
        stall_mode <= STALL_NONE;
        sender_idles = 1'b0;
        run_texts(TEXT_ITEMS, 1'b0);

        // widest stride makes the address overflow well inside the frame
        configure(4'd3, 32'hFFFF_FFFF, 13'd8191);
        stall_mode <= STALL_HEAVY;
        sender_idles = 1'b1;
        run_texts(TEXT_ITEMS, 1'b0);

        // stride of zero: address equals x
        configure(SIDE_W'($urandom_range(1, 15)), $urandom, 13'd0);
        stall_mode <= STALL_LIGHT;
        sender_idles = 1'b0;
        run_texts(TEXT_ITEMS, 1'b0);

        configure(4'd7, $urandom, STRIDE_W'($urandom_range(1, 4096)));
        stall_mode <= STALL_HEAVY;
        sender_idles = 1'b1;
        run_texts(TEXT_ITEMS, 1'b1);

        configure(4'd1, $urandom, 13'd640);
        stall_mode <= STALL_LIGHT;
        sender_idles = 1'b1;
        run_texts(TEXT_ITEMS, 1'b0);

        configure(4'd15, $urandom, STRIDE_W'($urandom_range(1, 4096)));
        stall_mode <= STALL_LIGHT;
        sender_idles = 1'b1;
        run_pen_overrun();

        // wind down: everything owed must arrive, then let the pipeline settle
        drain_results();
        repeat (HOLD_OFF) @(posedge clk);
        failures = sb.mismatches + sb.owed_cmds.size();
        $display("ran %0d characters (%0d with lit cells) over eight register settings",
                 sb.chars_seen, sb.lit_chars);
        $display("%0d block commands checked, %0d out of range, pen x ceiling %s",
                 sb.cmds_checked, sb.oor_cmds, sb.pen_saturated ? "reached" : "not reached");
        $display("mismatches %0d, commands never seen %0d",
                 sb.mismatches, sb.owed_cmds.size());
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
